@@ hdl/acp_pkg.sv @@
// Types, constants and the xtime byte function for the AES-128 CTR packet cipher.
// No dependencies; imported by every module of the block except acp_fifo.
package acp_pkg;

  localparam int IV_SIZE = 8;
  localparam int BLOCK_SIZE = 16;

  localparam logic [0:0] KIND_ECHO = 1'b0;
  localparam logic [0:0] KIND_DATA = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW = 1'b1;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic [0:0]   kind;
    logic         newblk;
    logic [3:0]   bpos;
    logic [127:0] ctr;
  } entry_t;

  typedef logic [7:0] byte_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ hdl/acp_fifo.sv @@
// Short register queue between the classifying front and the cipher back end.
// Depends on nothing.
module acp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr) - CW'(rd);
    end
  end
endmodule

@@ hdl/acp_front.sv @@
// Front end: tracks packet, nonce and block position and builds queue entries.
// Depends on acp_pkg.
module acp_front import acp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       mode,
  output logic       push_entry,
  output entry_t     entry
);
  logic         in_packet;
  logic         mode_r;
  logic [3:0]   npos;
  logic [3:0]   bpos;
  logic [63:0]  ctr_hi;
  logic [63:0]  ctr_lo;
  logic         start;
  logic [3:0]   np;
  logic [3:0]   bp;
  logic         md;
  logic         in_nonce;

  always_comb begin
    start = first_byte | ~in_packet;
    np = start ? 4'd0 : npos;
    bp = start ? 4'd0 : bpos;
    md = start ? mode : mode_r;
    in_nonce = (np < 4'(IV_SIZE));
    entry.data = data_byte;
    entry.last = last_byte;
    entry.kind = in_nonce ? KIND_ECHO : KIND_DATA;
    entry.newblk = (bp == 4'd0);
    entry.bpos = bp;
    entry.ctr = {ctr_hi, ctr_lo};
    push_entry = accept & (~in_nonce | ~md);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      mode_r <= 1'b0;
      npos <= '0;
      bpos <= '0;
      ctr_hi <= '0;
      ctr_lo <= '0;
    end else if (accept) begin
      in_packet <= ~last_byte;
      mode_r <= md;
      if (in_nonce) begin
        ctr_hi <= {ctr_hi[55:0], data_byte};
        npos <= np + 4'd1;
        bpos <= '0;
        if (np == 4'(IV_SIZE - 1)) begin
          ctr_lo <= '0;
        end
      end else begin
        npos <= np;
        bpos <= bp + 4'd1;
        if (bp == 4'(BLOCK_SIZE - 1)) begin
          {ctr_hi, ctr_lo} <= {ctr_hi, ctr_lo} + 128'd1;
        end
      end
    end
  end
endmodule

@@ hdl/acp_aes.sv @@
// Iterative AES-128 encryption core, one round per cycle, keys expanded on the fly.
// Depends on acp_pkg.
module acp_aes import acp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] din,
  output logic         busy,
  output logic         done,
  output logic [127:0] dout
);
  logic [127:0] blk, rk;
  logic [7:0]   rcon;
  logic [3:0]   round;
  byte_t b [16];
  byte_t k [16];
  byte_t kn [16];
  byte_t t [16];
  byte_t m [16];
  byte_t a0, a1, a2, a3, al;
  logic [127:0] blk_next, rk_next;

  assign dout = blk;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = blk[127 - 8*i -: 8];
      k[i] = rk[127 - 8*i -: 8];
    end
    kn[0] = k[0] ^ SBOX[k[13]] ^ rcon;
    kn[1] = k[1] ^ SBOX[k[14]];
    kn[2] = k[2] ^ SBOX[k[15]];
    kn[3] = k[3] ^ SBOX[k[12]];
    for (int i = 4; i < 16; i++) begin
      kn[i] = k[i] ^ kn[i-4];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c + i] = SBOX[b[4*((c + i) % 4) + i]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (round != 4'd10) begin
        m[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        m[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        m[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        m[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end else begin
        m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      blk_next[127 - 8*i -: 8] = m[i] ^ kn[i];
      rk_next[127 - 8*i -: 8] = kn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
      rcon <= 8'h01;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        round <= 4'd1;
        rcon <= 8'h01;
        blk <= din ^ key;
        rk <= key;
      end else if (busy) begin
        blk <= blk_next;
        rk <= rk_next;
        rcon <= xtime(rcon);
        round <= round + 4'd1;
        if (round == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/aes128_ctr_packet_cipher.sv @@
// Top level of the AES-128 CTR packet cipher: key registers, queue, back end.
// Depends on acp_pkg, acp_front, acp_fifo and acp_aes.
//
// Bytes enter at one per cycle while the queue has room. Nonce bytes pass
// straight through the back end in mode 0 and are dropped in mode 1. The
// first payload byte of every 16-byte group waits for the iterative AES
// core to finish its keystream block; the other bytes of the group leave at
// one per cycle while the output is free or popped.
module aes128_ctr_packet_cipher import acp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        mode,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0]  key_high, key_low;
  logic         push_entry;
  entry_t       entry, head;
  logic         q_empty, q_full, rd;
  logic         aes_busy, aes_done, aes_start;
  logic [127:0] aes_out, ks;
  logic         kdone, out_valid, can_emit;

  assign cfg_ready = 1'b1;
  assign full = q_full;
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low <= cfg_data;
        default: ;
      endcase
    end
  end

  acp_front u_front (
    .clk, .rst,
    .accept(push & ~q_full),
    .data_byte, .first_byte, .last_byte, .mode,
    .push_entry, .entry
  );

  acp_fifo #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_fifo (
    .clk, .rst,
    .wr(push_entry), .wdata(entry),
    .rd, .rdata(head),
    .full(q_full), .empty(q_empty)
  );

  assign aes_start = ~q_empty & (head.kind == KIND_DATA) & head.newblk & ~kdone & ~aes_busy
                     & ~aes_done;

  acp_aes u_aes (
    .clk, .rst,
    .start(aes_start), .key({key_high, key_low}), .din(head.ctr),
    .busy(aes_busy), .done(aes_done), .dout(aes_out)
  );

  assign can_emit = ~out_valid | pop;
  assign rd = ~q_empty & can_emit & ((head.kind == KIND_ECHO) | ~head.newblk | kdone);

  always_ff @(posedge clk) begin
    if (aes_done) begin
      ks <= aes_out;
    end
    if (rd) begin
      out_byte <= (head.kind == KIND_ECHO) ? head.data
                                           : head.data ^ ks[{~head.bpos, 3'b000} +: 8];
      last_out <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kdone <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (aes_done) begin
        kdone <= 1'b1;
      end else if (rd && head.kind == KIND_DATA && head.newblk) begin
        kdone <= 1'b0;
      end
      if (rd) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for the AES-128 CTR packet cipher: byte packets in both
// modes, key changes between phases, random idling and a long output stall.
// Depends on acp_pkg and the aes128_ctr_packet_cipher RTL.
module tb_top;
  import acp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] b;
    logic       l;
  } cipher_out_t;

  localparam int LIMIT = 600000;

  logic        clk, rst, push, full, first_byte, last_byte, mode;
  logic [7:0]  data_byte, out_byte;
  logic        empty, pop, last_out, cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;

  aes128_ctr_packet_cipher dut (
    .clk, .rst, .push, .full, .data_byte, .first_byte, .last_byte, .mode,
    .empty, .pop, .out_byte, .last_out, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // predictor state
  logic [63:0]  key_hi, key_lo, ctr_hi, ctr_lo;
  byte_t        ks [16];
  int unsigned  blk_pos, nonce_pos;
  logic         pkt_mode, pkt_open;
  cipher_out_t  expected [$];

  int unsigned cycles, errors, hold_req;
  bit          no_idle;

  function automatic byte_t gmul2(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes128_block(logic [127:0] key, logic [127:0] blk);
    byte_t st [16];
    byte_t rk [16];
    byte_t t [16];
    byte_t rc, a0, a1, a2, a3, sum;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8 * i -: 8];
      st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      rk[0] ^= SBOX[rk[13]] ^ rc;
      rk[1] ^= SBOX[rk[14]];
      rk[2] ^= SBOX[rk[15]];
      rk[3] ^= SBOX[rk[12]];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
      rc = gmul2(rc);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4 * c + i] = SBOX[st[4 * ((c + i) % 4) + i]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          t[4 * c]     = a0 ^ sum ^ gmul2(a0 ^ a1);
          t[4 * c + 1] = a1 ^ sum ^ gmul2(a1 ^ a2);
          t[4 * c + 2] = a2 ^ sum ^ gmul2(a2 ^ a3);
          t[4 * c + 3] = a3 ^ sum ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
    return res;
  endfunction

  function automatic void predict_byte(byte_t d, logic f, logic l, logic m);
    logic [127:0] blk;
    if (f || !pkt_open) begin
      pkt_open = 1'b1;
      pkt_mode = m;
      nonce_pos = 0;
      blk_pos = 0;
    end
    if (nonce_pos < IV_SIZE) begin
      ctr_hi = {ctr_hi[55:0], d};
      nonce_pos++;
      if (nonce_pos == IV_SIZE) begin
        ctr_lo = '0;
        blk_pos = 0;
      end
      if (!pkt_mode) expected.push_back('{d, l});
    end else begin
      if (blk_pos == 0) begin
        blk = aes128_block({key_hi, key_lo}, {ctr_hi, ctr_lo});
        for (int i = 0; i < 16; i++) ks[i] = blk[127 - 8 * i -: 8];
      end
      expected.push_back('{d ^ ks[blk_pos], l});
      blk_pos++;
      if (blk_pos >= BLOCK_SIZE) begin
        blk_pos = 0;
        {ctr_hi, ctr_lo} = {ctr_hi, ctr_lo} + 128'd1;
      end
    end
    if (l) pkt_open = 1'b0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("aes128_ctr_packet_cipher verification failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    cipher_out_t e;
    if (!rst && pop && !empty) begin
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result byte %02h last %0b", out_byte, last_out);
      end else begin
        e = expected.pop_front();
        if (out_byte !== e.b || last_out !== e.l) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %02h/%0b actual %02h/%0b", e.b, e.l, out_byte, last_out);
        end
      end
    end
  end

  // receiver
  initial begin
    int unsigned gap;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req > 0) begin
        pop <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task automatic send_byte(byte_t d, logic f, logic l, logic m);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= d;
    first_byte <= f;
    last_byte <= l;
    mode <= m;
    do @(posedge clk); while (full);
    predict_byte(d, f, l, m);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi = val;
    else key_lo = val;
    @(posedge clk);
  endtask

  task automatic send_packet(int unsigned len, logic m, bit with_first, bit with_last);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), with_first && i == 0, with_last && i == len - 1,
                (i == 0) ? m : logic'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_key();
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    for (int i = 1; i < 8; i++) send_byte(8'hff, 1'b0, 1'b0, 1'b1);
    for (int i = 0; i < 17; i++) send_byte(i[0] ? 8'hff : 8'h00, 1'b0, i == 16, 1'b0);
    drain();
  endtask

  task automatic test_special_cases();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    send_byte(8'ha5, 1'b1, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b1, 1'b1);
    send_packet(5, 1'b0, 1, 1);
    send_packet(5, 1'b1, 1, 1);
    send_packet(12, 1'b1, 0, 1);
    send_packet(20, 1'b1, 0, 0);
    send_packet(30, 1'b0, 1, 1);
    drain();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent, len, kind;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 3) begin
        drain();
        write_key(REG_KEY_HIGH, {$urandom, $urandom});
        write_key(REG_KEY_LOW, {$urandom, $urandom});
      end
      no_idle = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 19);
      len = (kind == 0) ? $urandom_range(60, 90) : $urandom_range(1, 40);
      send_packet(len, logic'($urandom_range(0, 1)), kind != 1, kind != 2);
      sent += len;
    end
    no_idle = 0;
    drain();
  endtask

  task automatic test_output_stall();
    hold_req = 300;
    no_idle = 1;
    send_packet(48, 1'b0, 1, 1);
    no_idle = 0;
    drain();
  endtask

  task automatic test_key_extremes();
    write_key(REG_KEY_HIGH, '0);
    write_key(REG_KEY_LOW, '1);
    send_packet(24, 1'b1, 1, 1);
    drain();
    write_key(REG_KEY_HIGH, 64'h8000_0000_0000_0001);
    write_key(REG_KEY_LOW, '0);
    send_packet(24, 1'b0, 1, 1);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0; data_byte = '0; first_byte = 1'b0; last_byte = 1'b0; mode = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cycles = 0; errors = 0; hold_req = 0; no_idle = 0;
    key_hi = '0; key_lo = '0; ctr_hi = '0; ctr_lo = '0;
    blk_pos = 0; nonce_pos = 0; pkt_mode = 1'b0; pkt_open = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_special_cases();
    test_key_extremes();
    test_output_stall();
    test_random_traffic(900);
    if (errors == 0) $display("aes128_ctr_packet_cipher verification clean");
    else $display("aes128_ctr_packet_cipher verification failed");
    $finish;
  end
endmodule
